[design/mcis_pkg.sv]
// Shared types and constants for the multichannel IIR smoother.
`timescale 1ns / 1ps

package mcis_pkg;

    // Fixed field widths of the stream and configuration words.
    localparam int CMD_W       = 2;
    localparam int CHAN_W      = 4;
    localparam int WORD_W      = 16;
    localparam int VALUE_W     = 12;
    localparam int DIVISOR_W   = 16;
    localparam int REM_W       = DIVISOR_W + 1;
    localparam int SCALE_SHIFT = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Input tdata holds sample_word and read_channel, padded to whole bytes.
    localparam int S_DATA_W = ((WORD_W + CHAN_W + 7) / 8) * 8;
    // Output tdata holds out_channel and out_value.
    localparam int M_DATA_W = ((CHAN_W + VALUE_W + 7) / 8) * 8;

    localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MULTI_MODE     = 2'd0,
        REG_TAGGED_WORDS   = 2'd1,
        REG_FILTER_DIVISOR = 2'd2,
        REG_START_CHANNEL  = 2'd3
    } cfg_reg_t;

    // Control bundle from the sequencer to the channel state memory.
    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [CHAN_W-1:0] rd_chan;
        logic              wr_en;
        logic [CHAN_W-1:0] wr_chan;
    } mem_ctrl_t;

endpackage

[design/mcis_chan_mem.sv]
// Per-channel accumulator and remainder memory with valid bits for fast clearing.
`timescale 1ns / 1ps

module mcis_chan_mem #(
    parameter int NUM_CHANNELS = 16,
    parameter int ACC_W        = 28
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mcis_pkg::mem_ctrl_t             ctrl,
    input  logic signed [ACC_W-1:0]         wr_acc,
    input  logic signed [mcis_pkg::REM_W-1:0] wr_rem,
    output logic signed [ACC_W-1:0]         rd_acc,
    output logic signed [mcis_pkg::REM_W-1:0] rd_rem
);
    import mcis_pkg::*;

    localparam int IDX_W = $clog2(NUM_CHANNELS);

    logic signed [ACC_W-1:0] acc_mem [NUM_CHANNELS];
    logic signed [REM_W-1:0] rem_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic signed [ACC_W-1:0] rd_acc_reg;
    logic signed [REM_W-1:0] rd_rem_reg;
    logic [IDX_W-1:0]        rd_idx;
    logic [IDX_W-1:0]        wr_idx;

    assign rd_idx = ctrl.rd_chan[IDX_W-1:0];
    assign wr_idx = ctrl.wr_chan[IDX_W-1:0];

    // An entry that was not written since the last clear reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            valid_reg <= '0;
        end else if (ctrl.wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            acc_mem[wr_idx] <= wr_acc;
            rem_mem[wr_idx] <= wr_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_acc_reg <= valid_reg[rd_idx] ? acc_mem[rd_idx] : '0;
            rd_rem_reg <= valid_reg[rd_idx] ? rem_mem[rd_idx] : '0;
        end
    end

    assign rd_acc = rd_acc_reg;
    assign rd_rem = rd_rem_reg;

endmodule

[design/mcis_serial_div.sv]
// Bit-serial restoring divider for signed dividends, truncating toward zero.
`timescale 1ns / 1ps

module mcis_serial_div #(
    parameter int DIVIDEND_W = 30
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [DIVIDEND_W-1:0]        dividend,
    input  logic [mcis_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                done,
    output logic signed [DIVIDEND_W-1:0]        quotient,
    output logic signed [mcis_pkg::REM_W-1:0]   remainder
);
    import mcis_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    typedef enum logic [3:0] {
        DV_IDLE  = 4'b0001,
        DV_ABS   = 4'b0010,
        DV_SHIFT = 4'b0100,
        DV_SIGN  = 4'b1000
    } div_state_t;

    div_state_t              state_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic [DIVIDEND_W-1:0]   mag_reg;
    logic [DIVISOR_W-1:0]    part_reg;
    logic [DIVISOR_W-1:0]    divisor_reg;
    logic signed [DIVIDEND_W-1:0] quot_reg;
    logic signed [REM_W-1:0] rem_reg;
    logic [DIVISOR_W:0]      shifted;
    logic [DIVISOR_W+1:0]    trial;
    logic                    take;
    logic [REM_W-1:0]        rem_mag;

    // One quotient bit per cycle: bring down the next dividend bit and try a subtract.
    assign shifted = {part_reg, mag_reg[DIVIDEND_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, divisor_reg};
    assign take    = ~trial[DIVISOR_W+1];
    assign rem_mag = {1'b0, part_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DV_IDLE: begin
                    if (start) begin
                        state_reg <= DV_ABS;
                    end
                end
                DV_ABS: begin
                    state_reg <= DV_SHIFT;
                    cnt_reg   <= CNT_W'(DIVIDEND_W - 1);
                end
                DV_SHIFT: begin
                    if (cnt_reg == '0) begin
                        state_reg <= DV_SIGN;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                DV_SIGN: begin
                    state_reg <= DV_IDLE;
                    done_reg  <= 1'b1;
                end
                default: begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    mag_reg     <= dividend;
                    neg_reg     <= dividend[DIVIDEND_W-1];
                    divisor_reg <= divisor;
                    part_reg    <= '0;
                end
            end
            DV_ABS: begin
                mag_reg <= neg_reg ? (~mag_reg + 1'b1) : mag_reg;
            end
            DV_SHIFT: begin
                part_reg <= take ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
                mag_reg  <= {mag_reg[DIVIDEND_W-2:0], take};
            end
            DV_SIGN: begin
                quot_reg <= neg_reg ? (~mag_reg + 1'b1) : mag_reg;
                rem_reg  <= neg_reg ? (~rem_mag + 1'b1) : rem_mag;
            end
            default: begin
            end
        endcase
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

[design/multichannel_iir_smoother.sv]
// Top level of the multichannel first-order IIR smoother with its command sequencer.
`timescale 1ns / 1ps

// Channel    Direction  Handshake                 Contents
// s_         in         s_tvalid / s_tready       tuser: command; tdata: sample_word, read_channel
// m_         out        m_tvalid / m_tready       tdata: out_channel, out_value
// cfg_       in         cfg_valid / cfg_ready     cfg_index selects a register, cfg_data holds it
//
// The block takes a new input word only once the current one is finished. A filtered
// sample is the slowest item: the bit-serial divider works one quotient bit per cycle
// over the SAMPLE_BITS+18 bit difference. A read of an existing channel passes through
// fetch and done, a pass-through sample or a read of a missing channel through done alone,
// and a clear, a dropped sample or an ignored word finishes on acceptance.
// Reset is synchronous and active low; it empties every channel through the valid bits,
// so no clearing pass follows. A stalled output holds one finished word while the next
// input word is taken; only a second finished word waits for the first.

module multichannel_iir_smoother #(
    parameter int NUM_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] sample_word, [19:16] read_channel, [23:20] zero
    input  logic [mcis_pkg::S_DATA_W-1:0]     s_tdata,
    // [1:0] command
    input  logic [mcis_pkg::CMD_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] out_channel, [15:4] out_value
    output logic [mcis_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mcis_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mcis_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mcis_pkg::*;

    // The accumulator holds the sample scaled by 2^16; the difference needs two more bits.
    localparam int ACC_W  = SAMPLE_BITS + SCALE_SHIFT;
    localparam int DIFF_W = ACC_W + 2;
    localparam int IDX_W  = $clog2(NUM_CHANNELS);
    localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(NUM_CHANNELS);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FETCH  = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    // Configuration registers.
    logic                 multi_mode_reg;
    logic                 tagged_words_reg;
    logic [DIVISOR_W-1:0] filter_divisor_reg;
    logic [CHAN_W-1:0]    start_channel_reg;

    // Sequencer state.
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     robin_reg, robin_next;
    logic                 m_valid_reg, m_valid_next;

    // Item payload held while the item is worked on.
    logic [CHAN_W-1:0]      chan_reg, chan_next;
    logic                   is_read_reg, is_read_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [CHAN_W-1:0]      res_chan_reg, res_chan_next;
    logic [VALUE_W-1:0]     res_value_reg, res_value_next;
    logic [M_DATA_W-1:0]    m_data_reg, m_data_next;

    // Input word fields.
    logic                   accept;
    cmd_t                   in_cmd;
    logic [WORD_W-1:0]      in_word;
    logic [CHAN_W-1:0]      in_rch;
    logic [CHAN_W-1:0]      in_tag;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic signed [VALUE_W-1:0] pass_value;

    // Datapath.
    mem_ctrl_t               mem_ctrl;
    logic signed [ACC_W-1:0] rd_acc;
    logic signed [REM_W-1:0] rd_rem;
    logic signed [ACC_W-1:0] x_value;
    logic signed [DIFF_W-1:0] diff_value;
    logic signed [ACC_W-1:0] acc_new;
    logic [DIVISOR_W-1:0]    divisor_eff;
    logic                    div_start;
    logic                    div_done;
    logic signed [DIFF_W-1:0] div_quot;
    logic signed [REM_W-1:0] div_rem;
    logic [IDX_W-1:0]        robin_start;
    logic [IDX_W-1:0]        robin_adv;
    logic signed [VALUE_W-1:0] fetch_value;
    logic signed [VALUE_W-1:0] update_value;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign in_cmd     = cmd_t'(s_tuser);
    assign in_word    = s_tdata[WORD_W-1:0];
    assign in_rch     = s_tdata[WORD_W +: CHAN_W];
    assign in_tag     = in_word[WORD_W-1 -: CHAN_W];
    assign in_sample  = in_word[SAMPLE_BITS-1:0];
    assign pass_value = VALUE_W'($signed(in_sample));

    // The round-robin counter restarts at zero when the start channel does not exist.
    assign robin_start = ({1'b0, start_channel_reg} < CHAN_LIMIT) ?
                         start_channel_reg[IDX_W-1:0] : '0;
    assign robin_adv   = (robin_reg == IDX_W'(NUM_CHANNELS - 1)) ? '0 : robin_reg + 1'b1;

    // A zero divisor behaves as one.
    assign divisor_eff = (filter_divisor_reg == '0) ? DIVISOR_W'(1) : filter_divisor_reg;

    // d = rem + x - acc, with x the sample scaled by 2^16.
    assign x_value    = {sample_reg, SCALE_SHIFT'(0)};
    assign diff_value = DIFF_W'(rd_rem) + DIFF_W'(x_value) - DIFF_W'(rd_acc);
    assign acc_new    = rd_acc + ACC_W'(div_quot);

    // The reported value is the accumulator shifted down by 16, floor rounding.
    assign fetch_value  = VALUE_W'($signed(rd_acc[ACC_W-1:SCALE_SHIFT]));
    assign update_value = VALUE_W'($signed(acc_new[ACC_W-1:SCALE_SHIFT]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            multi_mode_reg     <= 1'b1;
            tagged_words_reg   <= 1'b0;
            filter_divisor_reg <= DIVISOR_RESET;
            start_channel_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MULTI_MODE:     multi_mode_reg     <= cfg_data[0];
                REG_TAGGED_WORDS:   tagged_words_reg   <= cfg_data[0];
                REG_FILTER_DIVISOR: filter_divisor_reg <= cfg_data[DIVISOR_W-1:0];
                REG_START_CHANNEL:  start_channel_reg  <= cfg_data[CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        robin_next     = robin_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        chan_next      = chan_reg;
        is_read_next   = is_read_reg;
        sample_next    = sample_reg;
        res_chan_next  = res_chan_reg;
        res_value_next = res_value_reg;
        mem_ctrl       = '0;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_SAMPLE: begin
                            sample_next  = in_sample;
                            is_read_next = 1'b0;
                            if (!multi_mode_reg) begin
                                // Single mode reports the raw sample on the start channel.
                                res_chan_next  = start_channel_reg;
                                res_value_next = pass_value;
                                state_next     = ST_DONE;
                            end else if (tagged_words_reg) begin
                                // A tag naming a missing channel drops the word silently.
                                if ({1'b0, in_tag} < CHAN_LIMIT) begin
                                    chan_next        = in_tag;
                                    mem_ctrl.rd_en   = 1'b1;
                                    mem_ctrl.rd_chan = in_tag;
                                    state_next       = ST_FETCH;
                                end
                            end else begin
                                chan_next        = CHAN_W'(robin_reg);
                                robin_next       = robin_adv;
                                mem_ctrl.rd_en   = 1'b1;
                                mem_ctrl.rd_chan = CHAN_W'(robin_reg);
                                state_next       = ST_FETCH;
                            end
                        end
                        CMD_READ: begin
                            if ({1'b0, in_rch} < CHAN_LIMIT) begin
                                chan_next        = in_rch;
                                is_read_next     = 1'b1;
                                mem_ctrl.rd_en   = 1'b1;
                                mem_ctrl.rd_chan = in_rch;
                                state_next       = ST_FETCH;
                            end else begin
                                // A missing channel reads as zero.
                                res_chan_next  = in_rch;
                                res_value_next = '0;
                                state_next     = ST_DONE;
                            end
                        end
                        CMD_CLEAR: begin
                            mem_ctrl.clear = 1'b1;
                            robin_next     = robin_start;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                if (is_read_reg) begin
                    res_chan_next  = chan_reg;
                    res_value_next = fetch_value;
                    state_next     = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                mem_ctrl.wr_en   = 1'b1;
                mem_ctrl.wr_chan = chan_reg;
                res_chan_next    = chan_reg;
                res_value_next   = update_value;
                state_next       = ST_DONE;
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_value_reg, res_chan_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            robin_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            robin_reg   <= robin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chan_reg      <= chan_next;
        is_read_reg   <= is_read_next;
        sample_reg    <= sample_next;
        res_chan_reg  <= res_chan_next;
        res_value_reg <= res_value_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    mcis_chan_mem #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ACC_W        (ACC_W)
    ) u_chan_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mem_ctrl),
        .wr_acc  (acc_new),
        .wr_rem  (div_rem),
        .rd_acc  (rd_acc),
        .rd_rem  (rd_rem)
    );

    mcis_serial_div #(
        .DIVIDEND_W (DIFF_W)
    ) u_serial_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (diff_value),
        .divisor   (divisor_eff),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_divide : assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide phase");

    // A finished result moves into a free or draining output register.
    a_done_loads_output : assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && (!m_valid_reg || m_tready)) |=>
        (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished result not handed to the output register");

    // The round-robin counter never names a missing channel.
    a_robin_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, CHAN_W'(robin_reg)} < CHAN_LIMIT))
        else $error("round-robin channel out of range");

endmodule
